[hdl/atbf_pkg.sv]
package atbf_pkg;

  typedef enum logic [2:0] {
    OP_VIDEO_WRITE   = 3'd0,
    OP_PALETTE_WRITE = 3'd1,
    OP_LOAD_REF      = 3'd2,
    OP_DRAW          = 3'd3,
    OP_END_LINE      = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    REG_MAP_BASE    = 3'd0,
    REG_TILE_BASE   = 3'd1,
    REG_MAP_SIZE    = 3'd2,
    REG_WRAP        = 3'd3,
    REG_X_STEP_PIX  = 3'd4,
    REG_Y_STEP_PIX  = 3'd5,
    REG_X_STEP_LINE = 3'd6,
    REG_Y_STEP_LINE = 3'd7
  } reg_index_t;

  localparam int CFG_INDEX_WIDTH = 4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [14:0]        mem_address;
    logic [15:0]        mem_data;
    logic signed [27:0] ref_x_value;
    logic signed [27:0] ref_y_value;
    logic [7:0]         pixel_x;
  } in_item_t;

  typedef struct packed {
    logic [14:0] colour;
    logic        transparent;
  } out_item_t;

  // Command passed from the front end to the fetch engine.
  typedef struct packed {
    logic        is_video_write;
    logic        is_palette_write;
    logic        is_draw;
    logic [14:0] mem_address;
    logic [15:0] mem_data;
    logic [7:0]  pixel_x;
    logic signed [27:0] ref_x;
    logic signed [27:0] ref_y;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  map_base_block;
    logic [1:0]  tile_base_block;
    logic [1:0]  map_size_select;
    logic        wrap_enable;
    logic signed [15:0] x_step_per_pixel;
    logic signed [15:0] y_step_per_pixel;
  } fetch_cfg_t;

endpackage

[hdl/atbf_front.sv]
module atbf_front import atbf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  in_item_t                   in_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                cfg_data,
  output cmd_t                       cmd,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output fetch_cfg_t                 fetch_cfg
);

  logic signed [27:0] reference_x;
  logic signed [27:0] reference_y;
  logic signed [15:0] x_step_per_line;
  logic signed [15:0] y_step_per_line;
  logic               accept;
  opcode_t            op;

  assign op        = opcode_t'(in_item.opcode);
  assign full      = !cmd_ready;
  assign accept    = push && cmd_ready;
  assign cfg_ready = 1'b1;

  // Every accepted item goes down; unused opcodes become no-ops.
  assign cmd_valid            = accept;
  assign cmd.is_video_write   = (op == OP_VIDEO_WRITE);
  assign cmd.is_palette_write = (op == OP_PALETTE_WRITE);
  assign cmd.is_draw          = (op == OP_DRAW);
  assign cmd.mem_address      = in_item.mem_address;
  assign cmd.mem_data         = in_item.mem_data;
  assign cmd.pixel_x          = in_item.pixel_x;
  assign cmd.ref_x            = reference_x;
  assign cmd.ref_y            = reference_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_x <= '0;
      reference_y <= '0;
    end else if (accept) begin
      if (op == OP_LOAD_REF) begin
        reference_x <= in_item.ref_x_value;
        reference_y <= in_item.ref_y_value;
      end else if (op == OP_END_LINE) begin
        reference_x <= reference_x + 28'(x_step_per_line);
        reference_y <= reference_y + 28'(y_step_per_line);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_cfg.map_base_block   <= '0;
      fetch_cfg.tile_base_block  <= '0;
      fetch_cfg.map_size_select  <= '0;
      fetch_cfg.wrap_enable      <= 1'b0;
      fetch_cfg.x_step_per_pixel <= 16'sd256;
      fetch_cfg.y_step_per_pixel <= '0;
      x_step_per_line            <= '0;
      y_step_per_line            <= 16'sd256;
    end else if (cfg_valid && cfg_index[CFG_INDEX_WIDTH-1] == 1'b0) begin
      unique case (reg_index_t'(cfg_index[2:0]))
        REG_MAP_BASE:    fetch_cfg.map_base_block   <= cfg_data[4:0];
        REG_TILE_BASE:   fetch_cfg.tile_base_block  <= cfg_data[1:0];
        REG_MAP_SIZE:    fetch_cfg.map_size_select  <= cfg_data[1:0];
        REG_WRAP:        fetch_cfg.wrap_enable      <= cfg_data[0];
        REG_X_STEP_PIX:  fetch_cfg.x_step_per_pixel <= cfg_data;
        REG_Y_STEP_PIX:  fetch_cfg.y_step_per_pixel <= cfg_data;
        REG_X_STEP_LINE: x_step_per_line            <= cfg_data;
        REG_Y_STEP_LINE: y_step_per_line            <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hdl/atbf_cmd_queue.sv]
module atbf_cmd_queue import atbf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t wr_cmd,
  input  logic wr_valid,
  output logic wr_ready,
  output cmd_t rd_cmd,
  output logic rd_valid,
  input  logic rd_ready
);

  // Two-entry queue.
  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_cmd   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 2'd1)
    else $error("queue count missed a write");
  assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree when empty");
`endif

endmodule

[hdl/atbf_fetch.sv]
module atbf_fetch import atbf_pkg::*; #(
  parameter int VIDEO_WORDS = 32768
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  fetch_cfg_t cfg,
  output out_item_t  result,
  output logic       result_valid,
  input  logic       result_ready
);

  localparam int VA_W = $clog2(VIDEO_WORDS);

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_MAP, F_TILE, F_PAL, F_OUT
  } fstate_t;

  fstate_t state, state_next;

  logic [15:0] video_memory [VIDEO_WORDS];
  logic [14:0] palette_memory [256];

  logic [15:0] vid_q;
  logic [14:0] pal_q;
  logic [VA_W-1:0] vid_raddr;
  logic [7:0]      pal_raddr;
  logic            vid_re;
  logic            pal_re;

  logic signed [24:0] prod_x;
  logic signed [24:0] prod_y;
  logic signed [27:0] base_x;
  logic signed [27:0] base_y;
  logic signed [28:0] sum_x;
  logic signed [28:0] sum_y;
  logic signed [20:0] tex_x;
  logic signed [20:0] tex_y;
  logic [9:0]         ux;
  logic [9:0]         uy;
  logic               outside;
  logic               odd_byte;
  logic [9:0]         span_mask;
  logic [7:0]         idx_byte;
  logic               drop;

  out_item_t out_reg;
  logic      out_full;
  logic      out_load;

  assign span_mask = 10'((128 << cfg.map_size_select) - 1);
  assign sum_x     = 29'(prod_x) + 29'(base_x);
  assign sum_y     = 29'(prod_y) + 29'(base_y);
  assign tex_x     = sum_x[28:8];
  assign tex_y     = sum_y[28:8];

  logic [23:0] map_byte;
  logic [23:0] tile_byte;
  assign map_byte  = 24'({cfg.map_base_block, 11'd0}) + 24'({uy[9:3], 7'd0} >> (3 - cfg.map_size_select))
                   + 24'(ux[9:3]);
  assign idx_byte  = odd_byte ? vid_q[15:8] : vid_q[7:0];
  assign tile_byte = 24'({cfg.tile_base_block, 14'd0}) + 24'({idx_byte, 6'd0})
                   + 24'({uy[2:0], ux[2:0]});

  // The result register is loaded once it is free or being emptied this cycle.
  assign out_load     = (state == F_OUT) && (!out_full || result_ready);
  assign cmd_ready    = (state == F_IDLE);
  assign result       = out_reg;
  assign result_valid = out_full;

  always_comb begin
    state_next = state;
    vid_re     = 1'b0;
    pal_re     = 1'b0;
    vid_raddr  = VA_W'(map_byte[23:1]);
    pal_raddr  = idx_byte;
    unique case (state)
      F_IDLE: if (cmd_valid && cmd_ready && cmd.is_draw) state_next = F_MUL;
      F_MUL:  state_next = F_MAP;
      F_MAP: begin
        vid_re     = 1'b1;
        state_next = F_TILE;
      end
      F_TILE: begin
        vid_re     = 1'b1;
        vid_raddr  = VA_W'(tile_byte[23:1]);
        state_next = F_PAL;
      end
      F_PAL: begin
        pal_re     = 1'b1;
        state_next = F_OUT;
      end
      F_OUT: if (out_load) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.is_video_write) begin
      video_memory[VA_W'(cmd.mem_address)] <= cmd.mem_data;
    end
    if (vid_re) vid_q <= video_memory[vid_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.is_palette_write) begin
      palette_memory[cmd.mem_address[7:0]] <= cmd.mem_data[14:0];
    end
    if (pal_re) pal_q <= palette_memory[pal_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.is_draw) begin
      prod_x <= cfg.x_step_per_pixel * $signed({1'b0, cmd.pixel_x});
      prod_y <= cfg.y_step_per_pixel * $signed({1'b0, cmd.pixel_x});
      base_x <= cmd.ref_x;
      base_y <= cmd.ref_y;
    end
    if (state == F_MUL) begin
      outside <= ((tex_x & ~21'(span_mask)) != '0) || ((tex_y & ~21'(span_mask)) != '0);
      ux      <= tex_x[9:0] & span_mask;
      uy      <= tex_y[9:0] & span_mask;
    end
    if (state == F_MAP) odd_byte <= map_byte[0];
    if (state == F_TILE) odd_byte <= tile_byte[0];
    if (state == F_PAL) drop <= (idx_byte == 8'd0) || (outside && !cfg.wrap_enable);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (result_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg.colour      <= drop ? 15'd0 : pal_q;
      out_reg.transparent <= drop;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst)
    (out_full && !result_ready) |=> (out_full && $stable(result)))
    else $error("waiting result changed before it was taken");
  assert property (@(posedge clk) disable iff (rst)
    (state == F_MAP) |-> $past(state) == F_MUL)
    else $error("map read out of sequence");
  assert property (@(posedge clk) disable iff (rst)
    (out_full && result.transparent) |-> result.colour == 15'd0)
    else $error("transparent result with colour");
  assert property (@(posedge clk) disable iff (rst)
    (state != F_IDLE) |-> !cmd_ready)
    else $error("command taken while busy");
`endif

endmodule

[hdl/affine_tile_background_fetch_top.sv]
// Channel   | Direction | Handshake            | Payload
// input     | in        | push / full          | in_item (in_item_t)
// result    | out       | empty / pop          | out_item (out_item_t)
// config    | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A draw transaction passes through six steps in the fetch engine: accept, multiply,
// map read, tile read, palette read and result write, bounded by the two
// dependent video memory reads on the single read port. Other transactions need
// only the accept step. A two-entry command queue lets the front accept while a
// draw is in flight. Reset is synchronous and clears control state only; memories
// are not cleared. A full result register holds a finished draw in its result
// write step until the waiting result is popped.
module affine_tile_background_fetch_top import atbf_pkg::*; #(
  parameter int VIDEO_WORDS = 32768
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  in_item_t                   in_item,
  output logic                       empty,
  input  logic                       pop,
  output out_item_t                  out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                cfg_data
);

  cmd_t       front_cmd;
  logic       front_valid;
  logic       front_ready;
  cmd_t       back_cmd;
  logic       back_valid;
  logic       back_ready;
  fetch_cfg_t fetch_cfg;
  logic       result_valid;

  // The front end tracks the reference point and snapshots it per command.
  atbf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .fetch_cfg (fetch_cfg)
  );

  atbf_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_cmd   (front_cmd),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .rd_cmd   (back_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready)
  );

  atbf_fetch #(.VIDEO_WORDS(VIDEO_WORDS)) u_fetch (
    .clk          (clk),
    .rst          (rst),
    .cmd          (back_cmd),
    .cmd_valid    (back_valid),
    .cmd_ready    (back_ready),
    .cfg          (fetch_cfg),
    .result       (out_item),
    .result_valid (result_valid),
    .result_ready (pop)
  );

  assign empty = !result_valid;

endmodule

[tb/sv/tb.sv]
module tb;
  import atbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VIDEO_WORDS = 32768;
  localparam int PALETTE_SIZE = 256;
  // Any index past the last register must be ignored by the block.
  localparam logic [CFG_INDEX_WIDTH-1:0] UNMAPPED_REG_INDEX = 4'd9;
  // Cycles allowed after the last result for in-flight writes to drain.
  localparam int DRAIN_CYCLES = 16;
  // Cycles with no transaction of any kind before the run is declared hung.
  localparam int HANG_LIMIT = 5000;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_item_t in_item;
  logic empty;
  logic pop;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [15:0] cfg_data;

  affine_tile_background_fetch_top #(.VIDEO_WORDS(VIDEO_WORDS)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of everything the block holds, kept in step with every
  // accepted transaction so each draw can be predicted on acceptance.
  logic [15:0] video_shadow [VIDEO_WORDS];
  logic [14:0] palette_shadow [PALETTE_SIZE];
  // Entries written so far; a draw is preceded by writes to whatever it reads.
  bit video_written [VIDEO_WORDS];
  bit palette_written [PALETTE_SIZE];
  logic signed [27:0] origin_x, origin_y;
  logic [4:0] map_base;
  logic [1:0] tile_base;
  logic [1:0] map_size;
  logic wrap_on;
  logic signed [15:0] dx_pixel, dy_pixel, dx_line, dy_line;

  // Pixels predicted but not yet popped from the block, oldest first.
  out_item_t pending_pixels [$];

  int errors = 0;
  int draws_sent = 0;
  int clear_pixels = 0;
  int reg_writes = 0;
  int stall_left = 0;
  int hang_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every input is known from time zero; reset is asserted from the start.
  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    in_item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Tile and map bytes are zero often enough that transparent pixels are common.
  function automatic logic [7:0] texel_byte();
    if ($urandom_range(0, 3) == 0) return 8'd0;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] video_byte(int unsigned byte_addr);
    logic [15:0] word;
    word = video_shadow[(byte_addr >> 1) % VIDEO_WORDS];
    return byte_addr[0] ? word[15:8] : word[7:0];
  endfunction

  // Maps the screen column through the affine transform into the map square.
  // Returns 0 when the texel lies outside and wrapping is off.
  function automatic bit locate_texel(input logic [7:0] column, output longint tex_x,
                                      output longint tex_y);
    longint sum_x, sum_y, span;
    sum_x = longint'(dx_pixel) * longint'(column) + longint'(origin_x);
    sum_y = longint'(dy_pixel) * longint'(column) + longint'(origin_y);
    // Arithmetic shift gives the floor of the division by 256.
    tex_x = sum_x >>> 8;
    tex_y = sum_y >>> 8;
    span = longint'(128) << map_size;
    if (tex_x < 0 || tex_x >= span || tex_y < 0 || tex_y >= span) begin
      if (!wrap_on) return 1'b0;
      // The span is a power of two, so masking is the positive modulo.
      tex_x = tex_x & (span - 1);
      tex_y = tex_y & (span - 1);
    end
    return 1'b1;
  endfunction

  function automatic int unsigned map_byte_addr(longint tex_x, longint tex_y);
    longint tiles;
    tiles = longint'(16) << map_size;
    return 32'(map_base) * 32'd2048 + 32'((tex_y / 8) * tiles + tex_x / 8);
  endfunction

  function automatic int unsigned texel_byte_addr(longint tex_x, longint tex_y,
                                                  logic [7:0] tile_no);
    return 32'(tile_base) * 32'd16384 + 32'(tile_no) * 32'd64
           + 32'((tex_y % 8) * 8 + tex_x % 8);
  endfunction

  function automatic out_item_t shade_pixel(logic [7:0] column);
    out_item_t px;
    longint tex_x, tex_y;
    bit visible;
    logic [7:0] tile_no;
    logic [7:0] index;
    px.colour = '0;
    px.transparent = 1'b1;
    visible = locate_texel(column, tex_x, tex_y);
    if (!visible) return px;
    tile_no = video_byte(map_byte_addr(tex_x, tex_y));
    index = video_byte(texel_byte_addr(tex_x, tex_y, tile_no));
    if (index != 8'd0) begin
      px.colour = palette_shadow[index];
      px.transparent = 1'b0;
    end
    return px;
  endfunction

  // Applies one accepted input transaction to the shadow state.
  task automatic track_item(in_item_t item);
    case (item.opcode)
      OP_VIDEO_WRITE: begin
        video_shadow[item.mem_address % VIDEO_WORDS] = item.mem_data;
        video_written[item.mem_address % VIDEO_WORDS] = 1'b1;
      end
      OP_PALETTE_WRITE: begin
        palette_shadow[item.mem_address[7:0]] = item.mem_data[14:0];
        palette_written[item.mem_address[7:0]] = 1'b1;
      end
      OP_LOAD_REF: begin
        origin_x = item.ref_x_value;
        origin_y = item.ref_y_value;
      end
      OP_END_LINE: begin
        // Sums wrap at 28 bits, as the registers do.
        origin_x = origin_x + 28'(dx_line);
        origin_y = origin_y + 28'(dy_line);
      end
      OP_DRAW: begin
        pending_pixels.push_back(shade_pixel(item.pixel_x));
        draws_sent++;
      end
      default: ;
    endcase
  endtask

  // Drives one item and waits for its transaction. Push is left high when no
  // gap follows, so the next item goes out on the very next edge.
  task automatic drive_item(in_item_t item, bit no_gap = 0);
    int gap;
    push <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full);
    track_item(item);
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic in_item_t noise_item();
    in_item_t item;
    item = in_item_t'(98'({$urandom, $urandom, $urandom, $urandom}));
    return item;
  endfunction

  function automatic in_item_t make_item(opcode_t op);
    in_item_t item;
    item = noise_item();
    item.opcode = op;
    return item;
  endfunction

  // Writes the video word holding a byte unless it already holds data.
  task automatic fill_video_word(int unsigned byte_addr);
    in_item_t item;
    int unsigned word_addr;
    word_addr = (byte_addr >> 1) % VIDEO_WORDS;
    if (video_written[word_addr]) return;
    item = make_item(OP_VIDEO_WRITE);
    item.mem_address = 15'(word_addr);
    item.mem_data = {texel_byte(), texel_byte()};
    drive_item(item);
  endtask

  // Makes sure the map byte, the tile byte and the palette entry that a draw
  // at this column reads have all been written before the draw goes out.
  task automatic prepare_draw(logic [7:0] column);
    in_item_t item;
    longint tex_x, tex_y;
    bit visible;
    logic [7:0] tile_no;
    logic [7:0] index;
    visible = locate_texel(column, tex_x, tex_y);
    if (!visible) return;
    fill_video_word(map_byte_addr(tex_x, tex_y));
    tile_no = video_byte(map_byte_addr(tex_x, tex_y));
    fill_video_word(texel_byte_addr(tex_x, tex_y, tile_no));
    index = video_byte(texel_byte_addr(tex_x, tex_y, tile_no));
    if (index != 8'd0 && !palette_written[index]) begin
      item = make_item(OP_PALETTE_WRITE);
      item.mem_address = {7'($urandom), index};
      drive_item(item);
    end
  endtask

  // Sends one item; a draw first gets the storage it reads filled in.
  task automatic send_item(in_item_t item, bit no_gap = 0);
    if (item.opcode == OP_DRAW) prepare_draw(item.pixel_x);
    drive_item(item, no_gap);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (index)
      REG_MAP_BASE: map_base = value[4:0];
      REG_TILE_BASE: tile_base = value[1:0];
      REG_MAP_SIZE: map_size = value[1:0];
      REG_WRAP: wrap_on = value[0];
      REG_X_STEP_PIX: dx_pixel = value;
      REG_Y_STEP_PIX: dy_pixel = value;
      REG_X_STEP_LINE: dx_line = value;
      REG_Y_STEP_LINE: dy_line = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Registers change only with the block idle: every pixel is out and the
  // writes that give no result have had time to land.
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Upper bits of the narrow registers are random; the block must drop them.
  task automatic load_settings(logic [4:0] mb, logic [1:0] tb, logic [1:0] ms, logic wr,
                               logic [15:0] xp, logic [15:0] yp,
                               logic [15:0] xl, logic [15:0] yl);
    wait_idle();
    write_reg(REG_MAP_BASE, {11'($urandom), mb});
    write_reg(REG_TILE_BASE, {14'($urandom), tb});
    write_reg(REG_MAP_SIZE, {14'($urandom), ms});
    write_reg(REG_WRAP, {15'($urandom), wr});
    write_reg(REG_X_STEP_PIX, xp);
    write_reg(REG_Y_STEP_PIX, yp);
    write_reg(REG_X_STEP_LINE, xl);
    write_reg(REG_Y_STEP_LINE, yl);
  endtask

  // Short directed sequence over field extremes and the corner cases.
  task automatic test_directed();
    in_item_t item;
    logic [7:0] probe_columns [6];
    probe_columns = '{8'd0, 8'd1, 8'd127, 8'd239, 8'd240, 8'd255};
    load_settings(5'd0, 2'd0, 2'd0, 1'b0, 16'sd256, 16'sd0, 16'sd0, 16'sd256);
    // Draws from the reset origin at the first and the widest columns,
    // including columns past the visible screen.
    foreach (probe_columns[i]) begin
      item = make_item(OP_DRAW);
      item.pixel_x = probe_columns[i];
      send_item(item);
    end
    // Palette write with the top data bit set and a high address.
    item = make_item(OP_PALETTE_WRITE);
    item.mem_address = 15'h7FFF;
    item.mem_data = 16'hFFFF;
    send_item(item);
    // Opcodes past the defined set must do nothing.
    for (int op = 5; op < 8; op++) begin
      item = noise_item();
      item.opcode = 3'(op);
      send_item(item);
    end
    // Extreme origins, then line steps that overflow the 28-bit origin.
    item = make_item(OP_LOAD_REF);
    item.ref_x_value = 28'sh7FFFFFF;
    item.ref_y_value = -28'sh8000000;
    send_item(item);
    send_item(make_item(OP_DRAW));
    load_settings(5'd31, 2'd3, 2'd3, 1'b1, 16'sh7FFF, -16'sh8000, 16'sh7FFF, -16'sh8000);
    // A write to a register that does not exist must leave all of them alone.
    write_reg(UNMAPPED_REG_INDEX, 16'hFFFF);
    item = make_item(OP_END_LINE);
    send_item(item);
    item = make_item(OP_DRAW);
    item.pixel_x = 8'd255;
    send_item(item);
    item = make_item(OP_LOAD_REF);
    item.ref_x_value = -28'sh8000000;
    item.ref_y_value = 28'sh7FFFFFF;
    send_item(item);
    send_item(make_item(OP_END_LINE));
    item = make_item(OP_DRAW);
    item.pixel_x = 8'd0;
    send_item(item);
  endtask

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
      default: return 16'($urandom_range(0, 1024) - 512);
    endcase
  endfunction

  // Scanlines: load an origin, draw a run of columns, end the line, with
  // noise items scattered among them. Most origins lie inside the map.
  task automatic test_scanlines(int phase_count, int items_per_phase);
    in_item_t item;
    int sent, draws;
    int unsigned span_fixed;
    logic [7:0] column;
    for (int phase = 0; phase < phase_count; phase++) begin
      case (phase)
        0: load_settings(5'd0, 2'd0, 2'd0, 1'b0, 16'sd256, 16'sd0, 16'sd0, 16'sd256);
        1: load_settings(5'd31, 2'd3, 2'd3, 1'b1, -16'sh8000, 16'sh7FFF,
                         -16'sh8000, 16'sh7FFF);
        2: load_settings(5'd17, 2'd1, 2'd3, 1'b0, 16'sd181, -16'sd181, 16'sd181, 16'sd181);
        default: load_settings(5'($urandom), 2'($urandom), 2'($urandom), 1'($urandom),
                               pick_step(), pick_step(), pick_step(), pick_step());
      endcase
      span_fixed = (128 << map_size) * 256;
      sent = 0;
      while (sent < items_per_phase) begin
        item = make_item(OP_LOAD_REF);
        if ($urandom_range(0, 4) != 0) begin
          item.ref_x_value = 28'($urandom_range(0, span_fixed - 1));
          item.ref_y_value = 28'($urandom_range(0, span_fixed - 1));
        end
        send_item(item);
        sent++;
        for (int line = $urandom_range(1, 3); line > 0; line--) begin
          draws = $urandom_range(2, 16);
          column = 8'($urandom_range(0, 40));
          repeat (draws) begin
            if ($urandom_range(0, 9) == 0) item = noise_item();
            else begin
              item = make_item(OP_DRAW);
              item.pixel_x = column;
              column = column + 8'($urandom_range(1, 24));
            end
            send_item(item);
            sent++;
          end
          send_item(make_item(OP_END_LINE));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_scanlines(8, 85);
    wait_idle();
    $display("Checked %0d drawn pixels (%0d transparent) over %0d register writes.",
             draws_sent, clear_pixels, reg_writes);
    $display("Settings spanned every map size, both wrap modes and extreme step values.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Reset values of the shadow registers match the block's own.
  initial begin
    origin_x = '0;
    origin_y = '0;
    map_base = '0;
    tile_base = '0;
    map_size = '0;
    wrap_on = 1'b0;
    dx_pixel = 16'sd256;
    dy_pixel = 16'sd0;
    dx_line = 16'sd0;
    dy_line = 16'sd256;
  end

  // The receiver stalls in random bursts and otherwise pops at full rate.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial pop <= 1'b0;

  task automatic report_mismatch(string what, int expected_val, int actual_val);
    $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what,
             expected_val, actual_val);
    errors++;
  endtask

  // Each popped pixel is checked against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && pop && !empty) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel, queue depth", 0, 1);
      end else begin
        want = pending_pixels.pop_front();
        if (want.transparent) clear_pixels++;
        if (out_item.colour !== want.colour)
          report_mismatch("colour", want.colour, out_item.colour);
        if (out_item.transparent !== want.transparent)
          report_mismatch("transparent", want.transparent, out_item.transparent);
      end
    end
  end

  // A long stretch with no transaction on any channel means the block hung.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", HANG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

endmodule

[sim.f]
hdl/atbf_pkg.sv
hdl/atbf_front.sv
hdl/atbf_cmd_queue.sv
hdl/atbf_fetch.sv
hdl/affine_tile_background_fetch_top.sv
tb/sv/tb.sv
